### src/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the light box triangle cull
// Field widths, outcode bits, command and register codes, channel words.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int INDEX_W    = 10;
    localparam int SLOT_COUNT = 1 << INDEX_W;
    localparam int POS_W      = 24;
    localparam int NORM_W     = 16;
    localparam int RADIUS_W   = 23;
    localparam int DIFF_W     = POS_W + 1;
    localparam int PROD_W     = DIFF_W + NORM_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int CODE_W     = 6;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = POS_W;

    localparam logic [CODE_W-1:0] CODE_X_ABOVE = 6'h01;
    localparam logic [CODE_W-1:0] CODE_X_BELOW = 6'h02;
    localparam logic [CODE_W-1:0] CODE_Y_ABOVE = 6'h04;
    localparam logic [CODE_W-1:0] CODE_Y_BELOW = 6'h08;
    localparam logic [CODE_W-1:0] CODE_Z_ABOVE = 6'h10;
    localparam logic [CODE_W-1:0] CODE_Z_BELOW = 6'h20;
    localparam logic [CODE_W-1:0] CODE_BACKFACE = 6'h3F;

    typedef enum logic
    {
        CMD_LOAD     = 1'b0,
        CMD_TRIANGLE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_LIGHT_X      = 2'd0,
        CFG_LIGHT_Y      = 2'd1,
        CFG_LIGHT_Z      = 2'd2,
        CFG_LIGHT_RADIUS = 2'd3
    } cfg_reg_t;

    typedef struct packed
    {
        cmd_t                     command;
        logic [INDEX_W-1:0]       vertex_index;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic [INDEX_W-1:0]       corner_a;
        logic [INDEX_W-1:0]       corner_b;
        logic [INDEX_W-1:0]       corner_c;
    } req_word_t;

    typedef struct packed
    {
        logic [INDEX_W-1:0] lit_a;
        logic [INDEX_W-1:0] lit_b;
        logic [INDEX_W-1:0] lit_c;
    } lit_word_t;

endpackage

### src/lsc_if.sv
// ----------------------------------------------------------------------------
// lsc_if: valid/ready channels of the light box triangle cull
// One interface for the request words, one for the lit triangle words.
// ----------------------------------------------------------------------------
interface lsc_req_if;
    import lsc_pkg::*;

    logic      valid;
    logic      ready;
    req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lsc_lit_if;
    import lsc_pkg::*;

    logic      valid;
    logic      ready;
    lit_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/light_sphere_triangle_cull.sv
// ----------------------------------------------------------------------------
// light_sphere_triangle_cull: triangle culling against a point light's box
// The request channel carries two kinds of word. A load word computes the
// outcode of one vertex against the light box (all ones when the vertex
// faces away from the light) and stores it in the clip code memory. A
// triangle word reads the codes of its three corners and is passed on the
// result channel unless all three corners lie outside one face of the box.
// Users write light position and radius through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block does not enforce this. One word
// is accepted per clock cycle while request.ready is high. A passing triangle
// goes through the difference stage, the product stage, then the clip code
// memory stage whose registered read ports feed the output register. Three
// copies of the code memory give the three corner reads in the same cycle.
// Reset clears the light registers and the pipeline valids; the code memory
// is not cleared and must be loaded before a triangle uses a slot. While the
// receiver stalls the output register holds its word and the stages in front
// keep filling, so request.ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module light_sphere_triangle_cull
#(
    parameter int MAX_VERTICES = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    lsc_req_if.sink                           request,
    lsc_lit_if.source                         result
);
    import lsc_pkg::*;

    localparam int DEPTH  = (MAX_VERTICES < SLOT_COUNT) ? MAX_VERTICES : SLOT_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [INDEX_W:0] DEPTH_LIMIT = (INDEX_W + 1)'(DEPTH);

    // Light registers.
    logic signed [POS_W-1:0] light_x_reg;
    logic signed [POS_W-1:0] light_y_reg;
    logic signed [POS_W-1:0] light_z_reg;
    logic [RADIUS_W-1:0]     radius_reg;

    // Stage 1: light minus position.
    logic                     s1_valid_reg;
    cmd_t                     s1_cmd_reg;
    logic [INDEX_W-1:0]       s1_slot_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg;
    logic signed [DIFF_W-1:0] s1_dy_reg;
    logic signed [DIFF_W-1:0] s1_dz_reg;
    logic signed [NORM_W-1:0] s1_nx_reg;
    logic signed [NORM_W-1:0] s1_ny_reg;
    logic signed [NORM_W-1:0] s1_nz_reg;
    lit_word_t                s1_tri_reg;

    // Stage 2: products and per-axis box bits.
    logic                     s2_valid_reg;
    cmd_t                     s2_cmd_reg;
    logic [INDEX_W-1:0]       s2_slot_reg;
    logic signed [PROD_W-1:0] s2_px_reg;
    logic signed [PROD_W-1:0] s2_py_reg;
    logic signed [PROD_W-1:0] s2_pz_reg;
    logic [CODE_W-1:0]        s2_axis_reg;
    lit_word_t                s2_tri_reg;

    // Stage 3: corner codes read from memory.
    logic                     s3_valid_reg;
    lit_word_t                s3_tri_reg;
    logic [2:0]               s3_in_range_reg;
    logic [CODE_W-1:0]        rd_a_reg;
    logic [CODE_W-1:0]        rd_b_reg;
    logic [CODE_W-1:0]        rd_c_reg;

    // Output register.
    logic                     out_valid_reg;
    lit_word_t                out_data_reg;

    logic [CODE_W-1:0] mem_a [DEPTH];
    logic [CODE_W-1:0] mem_b [DEPTH];
    logic [CODE_W-1:0] mem_c [DEPTH];

    logic out_free;
    logic take3;
    logic take2;
    logic take1;

    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [DIFF_W-1:0] dz_next;
    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] py_next;
    logic signed [PROD_W-1:0] pz_next;
    logic signed [DIFF_W-1:0] radius_pos;
    logic signed [DIFF_W-1:0] radius_neg;
    logic [CODE_W-1:0]        axis_next;
    logic signed [DOT_W-1:0]  dot;
    logic [CODE_W-1:0]        code;
    logic                     wr_en;
    logic [2:0]               in_range_next;
    logic [CODE_W-1:0]        code_a;
    logic [CODE_W-1:0]        code_b;
    logic [CODE_W-1:0]        code_c;
    logic                     culled;

    // A stage takes a new word when it is empty or its word moves on.
    assign out_free      = !out_valid_reg || result.ready;
    assign take3         = !s3_valid_reg || out_free;
    assign take2         = !s2_valid_reg || take3;
    assign take1         = !s1_valid_reg || take2;
    assign request.ready = take1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= '0;
            radius_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_LIGHT_X:      light_x_reg <= cfg_data[POS_W-1:0];
                CFG_LIGHT_Y:      light_y_reg <= cfg_data[POS_W-1:0];
                CFG_LIGHT_Z:      light_z_reg <= cfg_data[POS_W-1:0];
                CFG_LIGHT_RADIUS: radius_reg  <= cfg_data[RADIUS_W-1:0];
                default:          light_x_reg <= light_x_reg;
            endcase
        end
    end

    always_comb
    begin
        dx_next = DIFF_W'(light_x_reg) - DIFF_W'(request.data.pos_x);
        dy_next = DIFF_W'(light_y_reg) - DIFF_W'(request.data.pos_y);
        dz_next = DIFF_W'(light_z_reg) - DIFF_W'(request.data.pos_z);
    end

    always_comb
    begin
        px_next    = s1_dx_reg * s1_nx_reg;
        py_next    = s1_dy_reg * s1_ny_reg;
        pz_next    = s1_dz_reg * s1_nz_reg;
        radius_pos = $signed({2'b00, radius_reg});
        radius_neg = -radius_pos;
        axis_next  = '0;
        if (s1_dx_reg > radius_pos) axis_next = axis_next | CODE_X_ABOVE;
        if (s1_dx_reg < radius_neg) axis_next = axis_next | CODE_X_BELOW;
        if (s1_dy_reg > radius_pos) axis_next = axis_next | CODE_Y_ABOVE;
        if (s1_dy_reg < radius_neg) axis_next = axis_next | CODE_Y_BELOW;
        if (s1_dz_reg > radius_pos) axis_next = axis_next | CODE_Z_ABOVE;
        if (s1_dz_reg < radius_neg) axis_next = axis_next | CODE_Z_BELOW;
    end

    // A vertex facing away from the light (or edge on) gets every bit set.
    always_comb
    begin
        dot  = DOT_W'(s2_px_reg) + DOT_W'(s2_py_reg) + DOT_W'(s2_pz_reg);
        code = (!dot[DOT_W-1] && (dot != '0)) ? s2_axis_reg : CODE_BACKFACE;
        wr_en = s2_valid_reg && (s2_cmd_reg == CMD_LOAD) && take3
                && ({1'b0, s2_slot_reg} < DEPTH_LIMIT);
        in_range_next[0] = {1'b0, s2_tri_reg.lit_a} < DEPTH_LIMIT;
        in_range_next[1] = {1'b0, s2_tri_reg.lit_b} < DEPTH_LIMIT;
        in_range_next[2] = {1'b0, s2_tri_reg.lit_c} < DEPTH_LIMIT;
    end

    // Loads write and triangles read at the same stage, so every older load
    // has reached the memory before a younger triangle reads it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[s2_slot_reg[ADDR_W-1:0]] <= code;
            mem_b[s2_slot_reg[ADDR_W-1:0]] <= code;
            mem_c[s2_slot_reg[ADDR_W-1:0]] <= code;
        end
        if (take3)
        begin
            rd_a_reg <= mem_a[s2_tri_reg.lit_a[ADDR_W-1:0]];
            rd_b_reg <= mem_b[s2_tri_reg.lit_b[ADDR_W-1:0]];
            rd_c_reg <= mem_c[s2_tri_reg.lit_c[ADDR_W-1:0]];
        end
    end

    // A corner beyond the store reads as code zero and never culls.
    always_comb
    begin
        code_a = s3_in_range_reg[0] ? rd_a_reg : '0;
        code_b = s3_in_range_reg[1] ? rd_b_reg : '0;
        code_c = s3_in_range_reg[2] ? rd_c_reg : '0;
        culled = |(code_a & code_b & code_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)
            begin
                s1_valid_reg <= request.valid;
            end
            if (take2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (take3)
            begin
                s3_valid_reg <= s2_valid_reg && (s2_cmd_reg == CMD_TRIANGLE);
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg && !culled;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            s1_cmd_reg        <= request.data.command;
            s1_slot_reg       <= request.data.vertex_index;
            s1_dx_reg         <= dx_next;
            s1_dy_reg         <= dy_next;
            s1_dz_reg         <= dz_next;
            s1_nx_reg         <= request.data.norm_x;
            s1_ny_reg         <= request.data.norm_y;
            s1_nz_reg         <= request.data.norm_z;
            s1_tri_reg.lit_a  <= request.data.corner_a;
            s1_tri_reg.lit_b  <= request.data.corner_b;
            s1_tri_reg.lit_c  <= request.data.corner_c;
        end
        if (take2)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_px_reg   <= px_next;
            s2_py_reg   <= py_next;
            s2_pz_reg   <= pz_next;
            s2_axis_reg <= axis_next;
            s2_tri_reg  <= s1_tri_reg;
        end
        if (take3)
        begin
            s3_tri_reg      <= s2_tri_reg;
            s3_in_range_reg <= in_range_next;
        end
        if (out_free)
        begin
            out_data_reg <= s3_tri_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

### src/lsc_checker.sv
// ----------------------------------------------------------------------------
// lsc_checker: port-level checks of the light box triangle cull
// Watches the top level's channels and is bound to every instance of it.
// ----------------------------------------------------------------------------
module lsc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               request_valid,
    input logic               request_ready,
    input lsc_pkg::cmd_t      request_command,
    input logic               result_valid,
    input logic               result_ready,
    input lsc_pkg::lit_word_t result_data
);
    import lsc_pkg::*;

    logic seen_triangle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_triangle_reg <= 1'b0;
        end
        else if (request_valid && request_ready && (request_command == CMD_TRIANGLE))
        begin
            seen_triangle_reg <= 1'b1;
        end
    end

    // Reset empties the output register by the next edge at the latest, even when
    // the reset was already low before the first edge.
    assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result word valid during reset");

    // Coming out of reset every stage is empty, so a word can be taken.
    assert property (@(posedge clk) $rose(rst_n) |-> request_ready)
        else $error("request not ready right after reset");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result word changed");

    // Only triangles produce results; loads alone never do.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> seen_triangle_reg)
        else $error("result word without any triangle accepted");

endmodule

bind light_sphere_triangle_cull lsc_checker u_lsc_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .request_valid   (request.valid),
    .request_ready   (request.ready),
    .request_command (request.data.command),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_data     (result.data)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the light box triangle cull
// Loads vertex outcodes and tests triangles under several light settings.
// Every accepted request word runs through a local outcode predictor, and
// lit triangle words are compared in order against the predicted ones.
// ----------------------------------------------------------------------------
module testbench;
    import lsc_pkg::*;

    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int PHASE_WORDS      = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lsc_req_if request_ch();
    lsc_lit_if result_ch();

    light_sphere_triangle_cull #(.MAX_VERTICES(SLOT_COUNT)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .result    (result_ch)
    );

    // Light registers as the block should hold them, and the outcode store.
    logic signed [POS_W-1:0] light_x;
    logic signed [POS_W-1:0] light_y;
    logic signed [POS_W-1:0] light_z;
    logic [RADIUS_W-1:0]     light_r;
    logic [CODE_W-1:0]       slot_code [SLOT_COUNT];

    req_word_t pending_words [$];
    lit_word_t lit_due [$];
    bit        slot_loaded [SLOT_COUNT];
    int        loaded_slots [$];
    int        error_count;

    int src_gap;
    bit src_steady;
    int sink_wait;
    bit sink_steady;
    bit hold_request;
    bit hold_taken;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [CODE_W-1:0] vertex_outcode(req_word_t w);
        longint dx;
        longint dy;
        longint dz;
        longint r;
        longint dot;
        logic [CODE_W-1:0] code;
        dx = longint'(light_x) - longint'(w.pos_x);
        dy = longint'(light_y) - longint'(w.pos_y);
        dz = longint'(light_z) - longint'(w.pos_z);
        r = longint'(light_r);
        dot = dx * longint'(w.norm_x) + dy * longint'(w.norm_y) + dz * longint'(w.norm_z);
        if (dot <= 0)
            return CODE_BACKFACE;
        code = '0;
        if (dx > r)
            code |= CODE_X_ABOVE;
        else if (dx < -r)
            code |= CODE_X_BELOW;
        if (dy > r)
            code |= CODE_Y_ABOVE;
        else if (dy < -r)
            code |= CODE_Y_BELOW;
        if (dz > r)
            code |= CODE_Z_ABOVE;
        else if (dz < -r)
            code |= CODE_Z_BELOW;
        return code;
    endfunction

    function automatic void track_word(req_word_t w);
        lit_word_t lit;
        if (w.command == CMD_LOAD)
            slot_code[w.vertex_index] = vertex_outcode(w);
        else if ((slot_code[w.corner_a] & slot_code[w.corner_b] & slot_code[w.corner_c]) == '0)
        begin
            lit.lit_a = w.corner_a;
            lit.lit_b = w.corner_b;
            lit.lit_c = w.corner_c;
            lit_due.push_back(lit);
        end
    endfunction

    function automatic void check_lit(lit_word_t got);
        lit_word_t want;
        if (lit_due.size() == 0)
        begin
            $error("lit word %0d %0d %0d with none predicted", got.lit_a, got.lit_b, got.lit_c);
            error_count++;
            return;
        end
        want = lit_due.pop_front();
        if (got.lit_a !== want.lit_a)
        begin
            $error("lit_a: expected %0d, got %0d", want.lit_a, got.lit_a);
            error_count++;
        end
        if (got.lit_b !== want.lit_b)
        begin
            $error("lit_b: expected %0d, got %0d", want.lit_b, got.lit_b);
            error_count++;
        end
        if (got.lit_c !== want.lit_c)
        begin
            $error("lit_c: expected %0d, got %0d", want.lit_c, got.lit_c);
            error_count++;
        end
    endfunction

    // Every field random; callers overwrite the ones that matter.
    function automatic req_word_t noise_word();
        req_word_t w;
        w.command      = cmd_t'($urandom_range(0, 1));
        w.vertex_index = INDEX_W'($urandom);
        w.pos_x        = POS_W'($urandom);
        w.pos_y        = POS_W'($urandom);
        w.pos_z        = POS_W'($urandom);
        w.norm_x       = NORM_W'($urandom);
        w.norm_y       = NORM_W'($urandom);
        w.norm_z       = NORM_W'($urandom);
        w.corner_a     = INDEX_W'($urandom);
        w.corner_b     = INDEX_W'($urandom);
        w.corner_c     = INDEX_W'($urandom);
        return w;
    endfunction

    function automatic void mark_loaded(int slot);
        if (!slot_loaded[slot])
        begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
    endfunction

    function automatic void push_load(int slot,
                                      logic signed [POS_W-1:0] px,
                                      logic signed [POS_W-1:0] py,
                                      logic signed [POS_W-1:0] pz,
                                      logic signed [NORM_W-1:0] nx,
                                      logic signed [NORM_W-1:0] ny,
                                      logic signed [NORM_W-1:0] nz);
        req_word_t w;
        w = noise_word();
        w.command      = CMD_LOAD;
        w.vertex_index = INDEX_W'(slot);
        w.pos_x        = px;
        w.pos_y        = py;
        w.pos_z        = pz;
        w.norm_x       = nx;
        w.norm_y       = ny;
        w.norm_z       = nz;
        pending_words.push_back(w);
        mark_loaded(slot);
    endfunction

    function automatic void push_triangle(int a, int b, int c);
        req_word_t w;
        w = noise_word();
        w.command  = CMD_TRIANGLE;
        w.corner_a = INDEX_W'(a);
        w.corner_b = INDEX_W'(b);
        w.corner_c = INDEX_W'(c);
        pending_words.push_back(w);
    endfunction

    // A coordinate within two radii of the light, now and then on the box face or one step past it.
    function automatic logic signed [POS_W-1:0] near_light(logic signed [POS_W-1:0] l);
        longint span;
        longint p;
        longint r;
        span = (light_r == 0) ? 64 : longint'(light_r);
        r = longint'(light_r) + $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0)
            p = ($urandom_range(0, 1) == 1) ? longint'(l) + r : longint'(l) - r;
        else
            p = longint'(l) + longint'($urandom_range(0, 4 * span)) - 2 * span;
        if (p > 8388607)
            p = 8388607;
        if (p < -8388608)
            p = -8388608;
        return POS_W'(p);
    endfunction

    // Mostly points toward the light so that the box test is reached.
    function automatic logic signed [NORM_W-1:0] facing_norm(longint d);
        int unsigned pick;
        longint      mag;
        pick = $urandom_range(0, 7);
        mag = $urandom_range(0, 16384);
        if (pick == 0)
            return NORM_W'($urandom);
        if ((d < 0) != (pick == 7))
            mag = -mag;
        return NORM_W'(mag);
    endfunction

    function automatic void push_group();
        int slot [3];
        int turn;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        for (int k = 0; k < 3; k++)
        begin
            slot[k] = $urandom_range(0, SLOT_COUNT - 1);
            px = near_light(light_x);
            py = near_light(light_y);
            pz = near_light(light_z);
            push_load(slot[k], px, py, pz,
                      facing_norm(longint'(light_x) - longint'(px)),
                      facing_norm(longint'(light_y) - longint'(py)),
                      facing_norm(longint'(light_z) - longint'(pz)));
        end
        turn = $urandom_range(0, 2);
        push_triangle(slot[turn], slot[(turn + 1) % 3], slot[(turn + 2) % 3]);
    endfunction

    function automatic int pick_loaded();
        return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
    endfunction

    function automatic void fill_random_phase(int word_count);
        int queued;
        int pick;
        req_word_t w;
        queued = 0;
        while (queued < word_count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                push_group();
                queued += 4;
            end
            else if (pick == 7)
            begin
                w = noise_word();
                w.command = CMD_LOAD;
                pending_words.push_back(w);
                mark_loaded(w.vertex_index);
                queued++;
            end
            else if (pick == 8)
            begin
                push_triangle(pick_loaded(), pick_loaded(), pick_loaded());
                queued++;
            end
            else
            begin
                // Vertex sitting on the light: the dot product is zero.
                push_load($urandom_range(0, SLOT_COUNT - 1), light_x, light_y, light_z,
                          NORM_W'($urandom), NORM_W'($urandom), NORM_W'($urandom));
                queued++;
            end
        end
    endfunction

    task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
    endtask

    task automatic set_light(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                             logic signed [POS_W-1:0] z, logic [RADIUS_W-1:0] r);
        write_reg(CFG_LIGHT_X, x);
        write_reg(CFG_LIGHT_Y, y);
        write_reg(CFG_LIGHT_Z, z);
        write_reg(CFG_LIGHT_RADIUS, CFG_DATA_W'(r));
        @(posedge clk);
        cfg_we <= 1'b0;
        light_x = x;
        light_y = y;
        light_z = z;
        light_r = r;
    endtask

    // Loads leave nothing behind to wait for, so a settling wait at the end lets them drain.
    task automatic wait_idle();
        while (pending_words.size() > 0 || request_ch.valid || lit_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_ch.valid <= 1'b0;
            request_ch.data  <= '0;
            src_gap          <= 0;
            src_steady       <= 1'b0;
        end
        else if (!request_ch.valid || request_ch.ready)
        begin
            if (request_ch.valid)
                track_word(request_ch.data);
            if (src_gap > 0)
            begin
                request_ch.valid <= 1'b0;
                src_gap          <= src_gap - 1;
            end
            else if (pending_words.size() > 0)
            begin
                request_ch.valid <= 1'b1;
                request_ch.data  <= pending_words.pop_front();
                if ($urandom_range(0, 39) == 0)
                    src_steady <= !src_steady;
                src_gap <= src_steady ? 0 : $urandom_range(0, 3);
            end
            else
                request_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : lit_monitor
        int stall;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            sink_wait       <= 0;
            sink_steady     <= 1'b0;
            hold_taken      <= 1'b0;
        end
        else
        begin
            stall = sink_wait;
            if (result_ch.valid && result_ch.ready)
            begin
                check_lit(result_ch.data);
                if ($urandom_range(0, 39) == 0)
                    sink_steady <= !sink_steady;
                stall = sink_steady ? 0 : $urandom_range(0, 3);
            end
            if (hold_request && !hold_taken)
            begin
                hold_taken <= 1'b1;
                stall = LONG_HOLD_CYCLES;
            end
            result_ch.ready <= (stall == 0);
            sink_wait       <= (stall > 0) ? stall - 1 : 0;
        end
    end

    initial
    begin
        error_count      = 0;
        hold_request     = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_LIGHT_X;
        cfg_data         = '0;
        request_ch.valid = 1'b0;
        request_ch.data  = '0;
        result_ch.ready  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Light at the origin with a box reaching 256 on each side.
        set_light(0, 0, 0, 256);
        push_load(0, 0, 0, 0, 16384, 0, 0);                     // on the light: backface
        push_load(1, -8388608, 0, 0, 16384, 0, 0);              // x above
        push_load(2, 8388607, 0, 0, -16384, 0, 0);              // x below
        push_load(3, 0, -256, 0, 0, 16384, 0);                  // exactly on the face
        push_load(4, 0, -257, 0, 0, 16384, 0);                  // y above
        push_load(5, 0, 257, 0, 0, -16384, 0);                  // y below
        push_load(6, 0, 0, -8388608, 0, 0, 32767);              // z above, oversized normal
        push_load(7, 0, 0, 8388607, 0, 0, -32768);              // z below, oversized normal
        push_load(1023, -8388608, -8388608, -8388608, 16384, 16384, 16384);
        push_load(8, -1000, -1000, -1000, -16384, 16384, 16384);
        push_load(9, 10, 10, 10, -16384, -16384, -16384);       // inside the box
        push_load(10, -1000, 0, 0, -16384, 0, 0);               // faces away
        push_triangle(1, 8, 1023);                              // all above in x: culled
        push_triangle(1, 2, 9);
        push_triangle(0, 10, 0);                                // all backfacing: culled
        push_triangle(0, 10, 9);
        push_triangle(4, 1023, 8);                              // all above in y: culled
        push_triangle(5, 6, 7);
        push_triangle(1023, 1023, 1023);
        push_triangle(3, 3, 3);
        push_load(1023, 1, 1, 1, -1, -1, -1);                   // overwrite a slot
        push_triangle(1023, 1, 0);
        wait_idle();

        // The receiver stalls for a long stretch at the start of this phase.
        set_light(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  $urandom_range(16, 4096));
        hold_request = 1'b1;
        fill_random_phase(PHASE_WORDS);
        wait_idle();

        set_light(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), 0);
        fill_random_phase(PHASE_WORDS);
        wait_idle();

        set_light(-8388608, -8388608, -8388608, 8388607);
        fill_random_phase(PHASE_WORDS);
        wait_idle();

        set_light(8388607, 8388607, 8388607, RADIUS_W'($urandom));
        fill_random_phase(PHASE_WORDS);
        wait_idle();

        set_light(POS_W'($urandom_range(0, 8191)) - 4096, POS_W'($urandom_range(0, 8191)) - 4096,
                  POS_W'($urandom_range(0, 8191)) - 4096, $urandom_range(1, 65536));
        fill_random_phase(PHASE_WORDS);
        wait_idle();

        set_light(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), RADIUS_W'($urandom));
        fill_random_phase(PHASE_WORDS);
        wait_idle();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
src/lsc_pkg.sv
src/lsc_if.sv
src/light_sphere_triangle_cull.sv
src/lsc_checker.sv
bench/testbench.sv
